[sv/bmh_pkg.sv]
// Shared types and constants for the binary min-heap queue.
// No dependencies.
package bmh_pkg;

    localparam int DefCapacity = 64;
    localparam int KeyW = 32;
    localparam int CountOutW = 7;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    // datapath operations issued by the controller
    localparam logic [3:0] OP_NONE      = 4'd0;
    localparam logic [3:0] OP_LOAD      = 4'd1;
    localparam logic [3:0] OP_WR_KEY    = 4'd2;
    localparam logic [3:0] OP_RD_PAR    = 4'd3;
    localparam logic [3:0] OP_UP        = 4'd4;
    localparam logic [3:0] OP_RD_LAST   = 4'd5;
    localparam logic [3:0] OP_TAKE_LAST = 4'd6;
    localparam logic [3:0] OP_RD_LEFT   = 4'd7;
    localparam logic [3:0] OP_RD_RIGHT  = 4'd8;
    localparam logic [3:0] OP_DN        = 4'd9;
    localparam logic [3:0] OP_RESULT    = 4'd10;

    typedef struct packed {
        logic [3:0] op;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic cnt_zero;
        logic cnt_one;
        logic pos_zero;
        logic left_out;
        logic par_gt;
        logic dn_stop;
        logic out_free;
    } dp_stat_t;

endpackage

[sv/binary_min_heap_queue.sv]
// Binary min-heap priority queue, top level.
// Depends on bmh_pkg, bmh_ctrl, bmh_datapath (which holds bmh_ram).
//
// Usage:
//   Input beats (s_): s_tuser is the command (0 insert, 1 delete minimum),
//   s_tdata holds the signed 32-bit key (ignored for delete).
//   Every input beat gives exactly one result beat (m_) describing the heap
//   after the operation: minimum key (0 when empty), count, empty flag and
//   an overflow flag for an insert dropped on a full heap. A delete on an
//   empty heap leaves it empty.
//   Each sift-up level is a parent read and then a compare/write, and each
//   sift-down level a left read, a right read and then a compare/write,
//   all through the single-read-port key RAM; one item at a time.
//   A finished result sits in the output register; the next input beat is
//   accepted while it waits, and a later result waits until it is taken.
//   Reset (aresetn low, synchronous) empties the heap at once; the key RAM
//   is not cleared since only slots that hold live keys are ever used.
//   A stalled m_tready holds the result register and the next result; no beat is lost.
module binary_min_heap_queue import bmh_pkg::*; #(
    parameter int Capacity = DefCapacity
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] key_in
    input  logic        s_tuser,   // [0] cmd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // [31:0] min_key, [38:32] entry_count,
                                   // [39] is_empty, [40] overflow, rest 0
);
    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic [$clog2(Capacity+1)-1:0] cnt;
    logic signed [KeyW-1:0] min_key;
    logic [CountOutW-1:0] entry_count;
    logic is_empty, overflow;

    bmh_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .in_cmd(s_tuser),
        .s_tready(s_tready), .stat(stat), .cmd(cmd)
    );

    bmh_datapath #(.Capacity(Capacity)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat), .cnt(cnt),
        .in_cmd(s_tuser), .in_key(s_tdata), .m_tready(m_tready),
        .m_valid(m_tvalid), .m_min_key(min_key), .m_count(entry_count),
        .m_empty(is_empty), .m_ovf(overflow)
    );

    assign m_tdata = {7'b0, overflow, is_empty, entry_count, min_key};

    // heap never holds more than Capacity keys
    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt <= ($clog2(Capacity+1))'(Capacity))
        else $error("heap count above capacity");

    // the block is busy right after taking a beat
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("accepted two beats back to back");

    // an empty result reports zero count and zero key
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && is_empty |-> entry_count == '0 && min_key == '0)
        else $error("empty result inconsistent");

    // a dropped insert only happens with the heap full
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && overflow |-> entry_count == CountOutW'(Capacity) && !is_empty)
        else $error("overflow flagged on non-full heap");
endmodule

[sv/bmh_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmh_ram #(
    parameter int Width = 32,
    parameter int Depth = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[sv/bmh_datapath.sv]
// Heap datapath: key store, count, hole position, compares, result register.
// Depends on bmh_pkg and bmh_ram.
module bmh_datapath import bmh_pkg::*; #(
    parameter int Capacity = DefCapacity
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [$clog2(Capacity+1)-1:0] cnt,
    input  logic                  in_cmd,
    input  logic signed [KeyW-1:0] in_key,
    input  logic                  m_tready,
    output logic                  m_valid,
    output logic signed [KeyW-1:0] m_min_key,
    output logic [CountOutW-1:0]  m_count,
    output logic                  m_empty,
    output logic                  m_ovf
);
    localparam int AW = $clog2(Capacity);
    localparam int CW = $clog2(Capacity + 1);
    localparam int LW = AW + 1;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic signed [KeyW-1:0] key_reg, key_next, lkey_reg, lkey_next, root_reg;
    logic ovf_reg, ovf_next;
    logic m_valid_reg, m_valid_next;
    logic signed [KeyW-1:0] m_key_reg;
    logic [CountOutW-1:0] m_cnt_reg;
    logic m_empty_reg, m_ovf_reg;

    logic we;
    logic [AW-1:0] waddr, raddr, parent, pos_m1;
    logic signed [KeyW-1:0] wdata, rdata, best_key;
    logic [LW-1:0] left_w, right_w, cnt_ext;
    logic right_in, gt_left, gt_right;
    logic [AW-1:0] best_pos;

    bmh_ram #(.Width(KeyW), .Depth(Capacity)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    always_comb begin
        pos_m1   = pos_reg - AW'(1);
        parent   = pos_m1 >> 1;
        left_w   = {pos_reg, 1'b1};
        right_w  = left_w + LW'(1);
        cnt_ext  = LW'(cnt_reg);
        right_in = right_w < cnt_ext;
        gt_left  = key_reg > lkey_reg;
        best_key = gt_left ? lkey_reg : key_reg;
        gt_right = right_in && (best_key > rdata);
        best_pos = gt_right ? right_w[AW-1:0] : left_w[AW-1:0];

        stat.full     = cnt_reg == CW'(Capacity);
        stat.cnt_zero = cnt_reg == '0;
        stat.cnt_one  = cnt_reg == CW'(1);
        stat.pos_zero = pos_reg == '0;
        stat.left_out = left_w >= cnt_ext;
        stat.par_gt   = rdata > key_reg;
        stat.dn_stop  = !(gt_left || gt_right);
        stat.out_free = !m_valid_reg || m_tready;
    end

    always_comb begin
        cnt_next = cnt_reg;
        pos_next = pos_reg;
        key_next = key_reg;
        lkey_next = lkey_reg;
        ovf_next = ovf_reg;
        m_valid_next = m_valid_reg && !m_tready;
        we = 1'b0;
        waddr = pos_reg;
        wdata = key_reg;
        raddr = parent;
        case (cmd.op)
            OP_LOAD: begin
                key_next = in_key;
                ovf_next = 1'b0;
                if (in_cmd == CMD_INSERT) begin
                    if (stat.full) begin
                        ovf_next = 1'b1;
                    end else begin
                        pos_next = cnt_reg[AW-1:0];
                        cnt_next = cnt_reg + CW'(1);
                    end
                end else if (!stat.cnt_zero) begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            OP_WR_KEY: we = 1'b1;
            OP_RD_PAR: raddr = parent;
            OP_UP: begin
                we = 1'b1;
                if (stat.par_gt) begin
                    wdata = rdata;
                    pos_next = parent;
                end
            end
            OP_RD_LAST: raddr = cnt_reg[AW-1:0];
            OP_TAKE_LAST: begin
                key_next = rdata;
                pos_next = '0;
            end
            OP_RD_LEFT: raddr = left_w[AW-1:0];
            OP_RD_RIGHT: begin
                raddr = right_w[AW-1:0];
                lkey_next = rdata;
            end
            OP_DN: begin
                we = 1'b1;
                if (!stat.dn_stop) begin
                    wdata = gt_right ? rdata : lkey_reg;
                    pos_next = best_pos;
                end
            end
            OP_RESULT: m_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        pos_reg <= pos_next;
        key_reg <= key_next;
        lkey_reg <= lkey_next;
        ovf_reg <= ovf_next;
        if (we && waddr == '0) begin
            root_reg <= wdata;
        end
        if (cmd.op == OP_RESULT) begin
            m_key_reg   <= stat.cnt_zero ? '0 : root_reg;
            m_cnt_reg   <= CountOutW'(cnt_reg);
            m_empty_reg <= stat.cnt_zero;
            m_ovf_reg   <= ovf_reg;
        end
    end

    assign cnt = cnt_reg;
    assign m_valid = m_valid_reg;
    assign m_min_key = m_key_reg;
    assign m_count = m_cnt_reg;
    assign m_empty = m_empty_reg;
    assign m_ovf = m_ovf_reg;
endmodule

[sv/bmh_ctrl.sv]
// Heap controller: sequences load, sift-up, sift-down and result steps.
// Depends on bmh_pkg.
module bmh_ctrl import bmh_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    input  logic     in_cmd,
    output logic     s_tready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_UP_CHK = 3'd1;
    localparam logic [2:0] ST_UP_CMP = 3'd2;
    localparam logic [2:0] ST_RD_LST = 3'd3;
    localparam logic [2:0] ST_TK_LST = 3'd4;
    localparam logic [2:0] ST_DN_CHK = 3'd5;
    localparam logic [2:0] ST_DN_RR  = 3'd6;
    localparam logic [2:0] ST_DN_CMP = 3'd7;

    logic [2:0] state_reg, state_next;
    logic done_reg, done_next;

    always_comb begin
        state_next = state_reg;
        done_next = done_reg;
        cmd.op = OP_NONE;
        s_tready = 1'b0;
        if (done_reg) begin
            if (stat.out_free) begin
                cmd.op = OP_RESULT;
                done_next = 1'b0;
                state_next = ST_IDLE;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    s_tready = 1'b1;
                    if (s_tvalid) begin
                        cmd.op = OP_LOAD;
                        if (in_cmd == CMD_INSERT) begin
                            if (stat.full) done_next = 1'b1;
                            else state_next = ST_UP_CHK;
                        end else if (stat.cnt_zero || stat.cnt_one) begin
                            done_next = 1'b1;
                        end else begin
                            state_next = ST_RD_LST;
                        end
                    end
                end
                ST_UP_CHK: begin
                    if (stat.pos_zero) begin
                        cmd.op = OP_WR_KEY;
                        done_next = 1'b1;
                    end else begin
                        cmd.op = OP_RD_PAR;
                        state_next = ST_UP_CMP;
                    end
                end
                ST_UP_CMP: begin
                    cmd.op = OP_UP;
                    if (stat.par_gt) state_next = ST_UP_CHK;
                    else done_next = 1'b1;
                end
                ST_RD_LST: begin
                    cmd.op = OP_RD_LAST;
                    state_next = ST_TK_LST;
                end
                ST_TK_LST: begin
                    cmd.op = OP_TAKE_LAST;
                    state_next = ST_DN_CHK;
                end
                ST_DN_CHK: begin
                    if (stat.left_out) begin
                        cmd.op = OP_WR_KEY;
                        done_next = 1'b1;
                    end else begin
                        cmd.op = OP_RD_LEFT;
                        state_next = ST_DN_RR;
                    end
                end
                ST_DN_RR: begin
                    cmd.op = OP_RD_RIGHT;
                    state_next = ST_DN_CMP;
                end
                ST_DN_CMP: begin
                    cmd.op = OP_DN;
                    if (stat.dn_stop) done_next = 1'b1;
                    else state_next = ST_DN_CHK;
                end
                default: state_next = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end
endmodule

[sim/tb_binary_min_heap_queue.sv]
// Self-checking testbench for the binary min-heap queue.
// Depends on bmh_pkg and binary_min_heap_queue; a scoreboard class predicts each result.
`timescale 1ns / 1ps

module tb_binary_min_heap_queue;
    import bmh_pkg::*;

    localparam int Cap = DefCapacity;
    localparam int WatchLimit = 20000;

    typedef struct packed {
        logic [31:0] min_key;
        logic [6:0]  entry_count;
        logic        is_empty;
        logic        overflow;
    } heap_status_t;

    // Mirror of the heap plus the queue of pending status beats.
    class heap_scoreboard;
        logic signed [31:0] keys[Cap];
        int                 fill;
        heap_status_t       pending[$];
        int                 errors;

        function void swap_keys(int a, int b);
            logic signed [31:0] t;
            t = keys[a];
            keys[a] = keys[b];
            keys[b] = t;
        endfunction

        function void note_beat(logic cmd, logic signed [31:0] key);
            heap_status_t st;
            int           pos;
            int           par;
            int           lc;
            int           best;
            logic         dropped;
            dropped = 1'b0;
            if (cmd == CMD_INSERT) begin
                if (fill >= Cap) begin
                    dropped = 1'b1;
                end else begin
                    keys[fill] = key;
                    pos = fill;
                    fill++;
                    // sift up while parent strictly larger
                    while (pos > 0) begin
                        par = (pos - 1) / 2;
                        if (!(keys[par] > keys[pos])) break;
                        swap_keys(par, pos);
                        pos = par;
                    end
                end
            end else if (fill > 0) begin
                fill--;
                keys[0] = keys[fill];
                pos = 0;
                // sift down, left child wins ties
                forever begin
                    lc = 2 * pos + 1;
                    best = pos;
                    if (lc >= fill) break;
                    if (keys[pos] > keys[lc]) best = lc;
                    if (lc + 1 < fill && keys[best] > keys[lc + 1]) best = lc + 1;
                    if (best == pos) break;
                    swap_keys(pos, best);
                    pos = best;
                end
            end
            st.min_key     = (fill > 0) ? keys[0] : 32'd0;
            st.entry_count = 7'(fill);
            st.is_empty    = (fill == 0);
            st.overflow    = dropped;
            pending.push_back(st);
        endfunction

        function void check_beat(logic [47:0] data);
            heap_status_t exp_st;
            if (data[47:41] != 7'd0) begin
                $error("pad bits: expected 0 actual %h", data[47:41]);
                errors++;
            end
            if (pending.size() == 0) begin
                $error("result beat with nothing expected: %h", data);
                errors++;
                return;
            end
            exp_st = pending.pop_front();
            if (data[31:0] != exp_st.min_key) begin
                $error("min_key: expected %0d actual %0d",
                       $signed(exp_st.min_key), $signed(data[31:0]));
                errors++;
            end
            if (data[38:32] != exp_st.entry_count) begin
                $error("entry_count: expected %0d actual %0d",
                       exp_st.entry_count, data[38:32]);
                errors++;
            end
            if (data[39] != exp_st.is_empty) begin
                $error("is_empty: expected %0b actual %0b", exp_st.is_empty, data[39]);
                errors++;
            end
            if (data[40] != exp_st.overflow) begin
                $error("overflow: expected %0b actual %0b", exp_st.overflow, data[40]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    heap_scoreboard sb = new();
    bit  quiet_tail = 1'b0;   // no idling in the last stretch
    bit  feeding_done = 1'b0;
    int  idle_cycles = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    binary_min_heap_queue i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Result side: check each accepted beat; random stall bursts.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_beat(m_tdata);
        if (aresetn && ((s_tvalid && s_tready) || (m_tvalid && m_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : result_stalls
        int burst;
        @(posedge aclk);
        forever begin
            if (!quiet_tail && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 19);
                m_tready <= 1'b0;
                repeat (burst) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge aclk);
        end
    end

    // Present one beat; may insert an idle burst before it.
    task automatic send_beat(logic cmd, logic [31:0] key);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        sb.note_beat(cmd, key);
    endtask

    function automatic logic [31:0] pick_key(int spread);
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, spread)) - 32'(spread / 2);
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int n;
        int target;
        int spread;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty delete, extremes, equal keys, drain to empty and beyond
        send_beat(CMD_DELETE, 32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 32'h7FFF_FFFF);
        send_beat(CMD_INSERT, 32'h8000_0000);
        send_beat(CMD_INSERT, 32'd0);
        send_beat(CMD_INSERT, 32'h8000_0000);
        send_beat(CMD_INSERT, 32'hFFFF_FFFF);
        send_beat(CMD_INSERT, 32'd5);
        send_beat(CMD_INSERT, 32'd5);
        repeat (7) send_beat(CMD_DELETE, 32'h5555_AAAA);
        send_beat(CMD_DELETE, 32'd0);
        send_beat(CMD_DELETE, 32'hAAAA_5555);

        // random: phases that fill, drain or churn; includes full-heap overflow
        n = 0;
        while (n < 1430) begin
            target = $urandom_range(0, 3);
            spread = ($urandom_range(0, 1) == 1) ? 8 : 1000;
            if (n > 1250) quiet_tail = 1'b1;
            repeat ($urandom_range(20, 90)) begin
                case (target)
                    0: send_beat(($urandom_range(0, 9) < 8) ? CMD_INSERT : CMD_DELETE,
                                 pick_key(spread));
                    1: send_beat(($urandom_range(0, 9) < 8) ? CMD_DELETE : CMD_INSERT,
                                 pick_key(spread));
                    default: send_beat(1'($urandom_range(0, 1)), pick_key(spread));
                endcase
                n++;
            end
        end
        s_tvalid <= 1'b0;
        feeding_done = 1'b1;
    end

    // End of run and watchdog.
    initial begin : finish_ctl
        wait (feeding_done);
        while (sb.pending.size() != 0 && idle_cycles < WatchLimit) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (sb.pending.size() != 0) sb.errors++;
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial begin : watchdog
        wait (idle_cycles >= WatchLimit);
        $display("CHECKS FAILED");
        $finish;
    end
endmodule
